FILE: sv/biq_pkg.sv
// shared constants, control word types and coefficient table for the biquad cascade
`default_nettype none

package biq_pkg;

    localparam int SECTIONS       = 6;
    localparam int COEF_FRAC_BITS = 14;
    localparam int STATE_WIDTH    = 32;

    localparam int SAMPLE_W    = 16;
    localparam int SAMPLE_FRAC = 16;
    localparam int ROM_FRAC    = 16;
    localparam int ROM_W       = 18;
    localparam int ROM_ROW_W   = 3;

    localparam int COEF_W     = COEF_FRAC_BITS + 2;
    localparam int COEF_SHIFT = ROM_FRAC - COEF_FRAC_BITS;
    localparam int X_W        = (STATE_WIDTH > SAMPLE_W + SAMPLE_FRAC) ? STATE_WIDTH
                                                                     : SAMPLE_W + SAMPLE_FRAC;
    localparam int PROD_W     = STATE_WIDTH + COEF_W;
    localparam int ACC_W      = X_W + COEF_W + 2;
    localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int STEP_W     = 3;

    localparam logic [SEC_W-1:0]         SEC_LAST   = SEC_W'(SECTIONS - 1);
    localparam logic [STEP_W-1:0]        STEP_START = '0;
    localparam logic signed [ACC_W-1:0]  ACC_HALF   = ACC_W'(2 ** (COEF_FRAC_BITS - 1));
    localparam logic signed [X_W:0]      OUT_HALF   = (X_W + 1)'(2 ** (SAMPLE_FRAC - 1));
    localparam logic signed [ROM_W:0]    ROM_HALF   = (ROM_W + 1)'((2 ** COEF_SHIFT) / 2);

    typedef enum logic [2:0] {
        COL_A1,
        COL_A2,
        COL_B0,
        COL_B1,
        COL_B2
    } coef_col_t;

    typedef enum logic [1:0] {
        OPND_D1,
        OPND_D2,
        OPND_W
    } opnd_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_LOAD_P,
        ACC_ADD_P,
        ACC_SUB_P
    } acc_op_t;

    typedef struct packed {
        logic      mul_en;
        coef_col_t col;
        opnd_t     opnd;
        acc_op_t   acc_op;
        logic      wr_w;
        logic      wr_y;
        logic      next_sec;
        logic      emit;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        mul_en: 1'b0, col: COL_A1, opnd: OPND_D1, acc_op: ACC_HOLD,
        wr_w: 1'b0, wr_y: 1'b0, next_sec: 1'b0, emit: 1'b0
    };

    // Q2.16 coefficient table, rounded half up to the working fraction width
    function automatic logic signed [COEF_W-1:0] coef_q(input logic [ROM_ROW_W-1:0] row,
                                                        input coef_col_t col);
        logic signed [ROM_W-1:0] a1;
        logic signed [ROM_W-1:0] a2;
        logic signed [ROM_W-1:0] b0;
        logic signed [ROM_W-1:0] b1;
        logic signed [ROM_W-1:0] b2;
        logic signed [ROM_W-1:0] raw;
        logic signed [ROM_W:0]   sum;
        case (row)
            3'd0: begin
                a1 = 18'sd28365;   a2 = -18'sd1281;  b0 = 18'sd9805;
                b1 = 18'sd13852;   b2 = 18'sd4356;
            end
            3'd1: begin
                a1 = -18'sd56876;  a2 = 18'sd43477;  b0 = 18'sd65536;
                b1 = -18'sd52318;  b2 = 18'sd51996;
            end
            3'd2: begin
                a1 = -18'sd84407;  a2 = 18'sd44730;  b0 = 18'sd65536;
                b1 = -18'sd52564;  b2 = 18'sd16038;
            end
            3'd3: begin
                a1 = -18'sd97905;  a2 = 18'sd48328;  b0 = 18'sd65536;
                b1 = -18'sd105100; b2 = 18'sd53120;
            end
            3'd4: begin
                a1 = -18'sd14019;  a2 = 18'sd51178;  b0 = 18'sd65536;
                b1 = -18'sd14029;  b2 = 18'sd50825;
            end
            3'd5: begin
                a1 = -18'sd129091; a2 = 18'sd63585;  b0 = 18'sd64553;
                b1 = -18'sd129106; b2 = 18'sd64553;
            end
            default: begin
                // pass-through section
                a1 = '0; a2 = '0; b0 = 18'sd65536; b1 = '0; b2 = '0;
            end
        endcase
        case (col)
            COL_A1:  raw = a1;
            COL_A2:  raw = a2;
            COL_B0:  raw = b0;
            COL_B1:  raw = b1;
            COL_B2:  raw = b2;
            default: raw = '0;
        endcase
        sum = (ROM_W + 1)'(raw) + ROM_HALF;
        sum = sum >>> COEF_SHIFT;
        return COEF_W'(sum);
    endfunction

endpackage

`default_nettype wire

FILE: sv/biq_ucode_rom.sv
// microprogram table: one control word per step of a biquad section
`default_nettype none

module biq_ucode_rom
    import biq_pkg::*;
(
    input  wire logic [STEP_W-1:0] step,
    output ctrl_t                  ctrl
);

    // products land in prod_reg and are used by the accumulator at the following step
    always_comb begin
        ctrl = CTRL_NOP;
        case (step)
            3'd0: begin
                ctrl.acc_op = ACC_LOAD_X;
                ctrl.mul_en = 1'b1; ctrl.col = COL_A1; ctrl.opnd = OPND_D1;
            end
            3'd1: begin
                ctrl.acc_op = ACC_SUB_P;
                ctrl.mul_en = 1'b1; ctrl.col = COL_A2; ctrl.opnd = OPND_D2;
            end
            3'd2: begin
                ctrl.acc_op = ACC_SUB_P;
                ctrl.mul_en = 1'b1; ctrl.col = COL_B1; ctrl.opnd = OPND_D1;
            end
            3'd3: begin
                // w taken from the feedback sum while the feed-forward sum starts
                ctrl.wr_w   = 1'b1;
                ctrl.acc_op = ACC_LOAD_P;
                ctrl.mul_en = 1'b1; ctrl.col = COL_B2; ctrl.opnd = OPND_D2;
            end
            3'd4: begin
                ctrl.acc_op = ACC_ADD_P;
                ctrl.mul_en = 1'b1; ctrl.col = COL_B0; ctrl.opnd = OPND_W;
            end
            3'd5: begin
                ctrl.acc_op = ACC_ADD_P;
            end
            3'd6: begin
                ctrl.wr_y     = 1'b1;
                ctrl.next_sec = 1'b1;
            end
            3'd7: begin
                ctrl.emit = 1'b1;
            end
            default: ctrl = CTRL_NOP;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/biq_datapath.sv
// shared multiplier and accumulator, and per-section delay registers, driven by the control word
`default_nettype none

module biq_datapath
    import biq_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic                       first_of_run,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic                       run,
    input  wire ctrl_t                      ctrl,
    input  wire logic [SEC_W-1:0]           sec,
    output logic signed [SAMPLE_W-1:0]      sample_q
);

    logic signed [STATE_WIDTH-1:0] d1_reg [SECTIONS];
    logic signed [STATE_WIDTH-1:0] d2_reg [SECTIONS];
    logic signed [STATE_WIDTH-1:0] w_reg;
    logic signed [X_W-1:0]         x_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    logic signed [COEF_W-1:0]      coef_val;
    logic signed [STATE_WIDTH-1:0] opnd_val;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       acc_sum;
    logic signed [ACC_W-1:0]       acc_rnd;
    logic signed [STATE_WIDTH-1:0] acc_sat;
    logic signed [X_W:0]           x_sum;
    logic signed [X_W:0]           x_rnd;

    assign coef_val = coef_q(ROM_ROW_W'(sec), ctrl.col);

    always_comb begin
        case (ctrl.opnd)
            OPND_D1: opnd_val = d1_reg[sec];
            OPND_D2: opnd_val = d2_reg[sec];
            OPND_W:  opnd_val = w_reg;
            default: opnd_val = '0;
        endcase
    end

    assign prod_next = coef_val * opnd_val;

    always_comb begin
        case (ctrl.acc_op)
            ACC_LOAD_X: acc_next = ACC_W'(x_reg) <<< COEF_FRAC_BITS;
            ACC_LOAD_P: acc_next = ACC_W'(prod_reg);
            ACC_ADD_P:  acc_next = acc_reg + ACC_W'(prod_reg);
            ACC_SUB_P:  acc_next = acc_reg - ACC_W'(prod_reg);
            default:    acc_next = acc_reg;
        endcase
    end

    // round half up, then clamp to the state width
    always_comb begin
        acc_sum = acc_reg + ACC_HALF;
        acc_rnd = acc_sum >>> COEF_FRAC_BITS;
        if ((&acc_rnd[ACC_W-1:STATE_WIDTH-1]) || !(|acc_rnd[ACC_W-1:STATE_WIDTH-1])) begin
            acc_sat = acc_rnd[STATE_WIDTH-1:0];
        end else if (acc_rnd[ACC_W-1]) begin
            acc_sat = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        end
    end

    // cascade output back to 16-bit sample scale
    always_comb begin
        x_sum = (X_W + 1)'(x_reg) + OUT_HALF;
        x_rnd = x_sum >>> SAMPLE_FRAC;
        if ((&x_rnd[X_W:SAMPLE_W-1]) || !(|x_rnd[X_W:SAMPLE_W-1])) begin
            sample_q = x_rnd[SAMPLE_W-1:0];
        end else if (x_rnd[X_W]) begin
            sample_q = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sample_q = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= X_W'(sample_in) <<< SAMPLE_FRAC;
        end else if (run && ctrl.wr_y) begin
            x_reg <= X_W'(acc_sat);
        end
        if (run && ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (run) begin
            acc_reg <= acc_next;
        end
        if (run && ctrl.wr_w) begin
            w_reg <= acc_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (start && first_of_run)) begin
            for (int i = 0; i < SECTIONS; i++) begin
                d1_reg[i] <= '0;
                d2_reg[i] <= '0;
            end
        end else if (run && ctrl.wr_y) begin
            d2_reg[sec] <= d1_reg[sec];
            d1_reg[sec] <= w_reg;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cascaded_biquad_iir_filter_top.sv
// cascaded biquad filter: step sequencer, handshakes and output register
// a result is registered at the output once every section has run; a new input sample is
// taken only when the previous one has been emitted, since the shared multiplier
// and accumulator run seven microcode steps per section, and an emit step after the last
// the next input transfer is taken while a finished result still waits at the output
// reset (aresetn low, synchronous) clears the sequencer, output valid and all delay values
`default_nettype none

module cascaded_biquad_iir_filter_top
    import biq_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_in,
    input  wire logic                       s_first_of_run,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_sample_out
);

    logic                       busy_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [SEC_W-1:0]           sec_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    ctrl_t                      ctrl;
    logic                       start;
    logic                       stall;
    logic                       run;
    logic signed [SAMPLE_W-1:0] sample_q;

    assign s_ready      = !busy_reg;
    assign start        = s_valid && s_ready;
    // emit waits until the previous result has been taken
    assign stall        = ctrl.emit && out_valid_reg && !m_ready;
    assign run          = busy_reg && !stall;
    assign m_valid      = out_valid_reg;
    assign m_sample_out = sample_out_reg;

    biq_ucode_rom u_rom (
        .step (step_reg),
        .ctrl (ctrl)
    );

    biq_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .first_of_run (s_first_of_run),
        .sample_in    (s_sample_in),
        .run          (run),
        .ctrl         (ctrl),
        .sec          (sec_reg),
        .sample_q     (sample_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_START;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // a new result replaces the one taken at the same edge
            if (run && ctrl.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_START;
                sec_reg  <= '0;
            end else if (run) begin
                if (ctrl.emit) begin
                    busy_reg       <= 1'b0;
                    step_reg       <= STEP_START;
                    sample_out_reg <= sample_q;
                end else if (ctrl.next_sec && sec_reg != SEC_LAST) begin
                    step_reg <= STEP_START;
                    sec_reg  <= sec_reg + SEC_W'(1);
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    a_start_step: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && step_reg == STEP_START && sec_reg == '0)
        else $error("sequencer did not restart at the first step");

    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> sec_reg <= SEC_LAST)
        else $error("section index out of range");

    a_emit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && ctrl.emit |-> sec_reg == SEC_LAST)
        else $error("result emitted before the last section");

    a_idle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> step_reg == STEP_START)
        else $error("step counter moved while idle");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        run && ctrl.emit |=> m_valid && !busy_reg)
        else $error("finished item did not raise the result");

endmodule

`default_nettype wire
